FILE: rtl/ktable_pkg.sv
// Shared definitions for the keyed table unit: operation and status codes,
// stream data widths and default parameter values. No dependencies.

package ktable_pkg;

	// Default sizing of the table.
	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_KEY_BITS    = 32;
	localparam int DEF_VALUE_BITS  = 32;

	// Fixed field widths on the stream ports.
	localparam int OP_W     = 3;
	localparam int KEY_IN_W = 32;
	localparam int VAL_IN_W = 32;
	localparam int STATUS_W = 2;
	localparam int VAL_OUT_W = 32;
	localparam int CNT_OUT_W = 6;

	// Packed request and response widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 48;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
	localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

FILE: rtl/ktable_ram.sv
// Single-port-write, single-port-read synchronous memory holding the
// table entries. Read data is registered. No dependencies.

module ktable_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/keyed_table_insert_erase_lookup_unit.sv
// Top level of the keyed table unit: request decode, scan sequencer and
// response register. Depends on ktable_pkg and ktable_ram.

// Usage
// -----
// Requests arrive on the s_ stream; each request carries one operation
// (insert, erase, clear, lookup or count) with a key and a value. Exactly one
// response per request leaves on the m_ stream, in request order, carrying
// the status, found flag, looked-up value, match count and the occupancy of
// the table after the operation.
// The entries live in one synchronous memory of {key, value} words. Insert,
// erase, lookup and count walk the stored entries one per cycle through the
// single read port, so the occupancy n sets the time of a request: a scan
// that misses reads every entry, compares the last read data and then sees
// that nothing is left (on an empty table it ends without a read), a hit
// ends it early. A missed insert writes the appended entry as the scan ends;
// an erase that hits then fetches the last entry and writes it into the
// freed slot; clear, a full-table insert and an unused operation need no
// scan at all. Each request then passes through ST_DONE, which loads the
// output register. One request is in work at a time; s_tready is high
// whenever the sequencer is idle, even while an earlier response still
// waits in the output register. If the receiver stalls, the finished
// response waits until the output register is free and the next request is
// held off meanwhile.
// Reset empties the table at once (the occupancy is cleared; no pass over the
// memory is needed) and drops any pending response.

module keyed_table_insert_erase_lookup_unit #(
	parameter int TABLE_DEPTH = ktable_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = ktable_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS  = ktable_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata, from bit 0: op[2:0], key_in[31:0], value_in[31:0], zero fill
	input  logic [ktable_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata, from bit 0: status[1:0], found, value_out[31:0],
	// match_count[5:0], occupancy[5:0], zero fill
	output logic [ktable_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = KEY_BITS + VALUE_BITS;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_LAST = 5'b00100,
		ST_MOVE = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// Latched request.
	logic [ktable_pkg::OP_W-1:0] op_q;
	logic [KEY_BITS-1:0]         key_q;
	logic [VALUE_BITS-1:0]       val_q;

	// Table occupancy and scan bookkeeping.
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] mcnt_q;

	// Result under construction.
	logic [ktable_pkg::STATUS_W-1:0] res_status_q;
	logic                            res_found_q;
	logic [VALUE_BITS-1:0]           res_value_q;

	logic                             m_tvalid_q;
	logic [ktable_pkg::M_TDATA_W-1:0] m_tdata_q;

	// Memory port signals.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [WW-1:0] ram_rdata;

	// Request field extraction and reduction to the stored widths.
	logic [ktable_pkg::OP_W-1:0] req_op;
	logic [63:0]                 req_key64;
	logic [63:0]                 req_val64;

	assign req_op    = s_tdata[2:0];
	assign req_key64 = 64'(s_tdata[34:3]);
	assign req_val64 = 64'(s_tdata[66:35]);

	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic [CW-1:0]         last_idx;
	logic                  issue;
	logic                  key_hit;
	logic                  val_hit;
	logic                  scan_end;
	logic                  out_free;

	assign rd_key   = ram_rdata[WW-1:VALUE_BITS];
	assign rd_val   = ram_rdata[VALUE_BITS-1:0];
	assign last_idx = count_q - 1'b1;
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign key_hit  = v_s1 && (rd_key == key_q);
	assign val_hit  = v_s1 && (rd_val == val_q);
	// Nothing in flight and nothing left to read: every entry has been seen.
	assign scan_end = !v_s1 && !issue;
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Memory access control.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_idx_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {key_q, val_q};
		unique case (state_q)
			ST_SCAN: begin
				ram_re = issue;
				// A missed insert appends at the end as the scan finishes.
				if (op_q == ktable_pkg::OP_INSERT && scan_end) begin
					ram_we = 1'b1;
				end
			end
			ST_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = last_idx[AW-1:0];
			end
			ST_MOVE: begin
				// The last entry moves into the freed slot.
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = ram_rdata;
			end
			ST_IDLE, ST_DONE: begin
			end
		endcase
	end

	ktable_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(WW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result fields widened, then cut to the response widths.
	logic [63:0] res_val64;
	logic [15:0] mcnt16;
	logic [15:0] occ16;

	assign res_val64 = 64'(res_value_q);
	assign mcnt16    = 16'(mcnt_q);
	assign occ16     = 16'(count_q);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			v_s1         <= 1'b0;
			m_tvalid_q   <= 1'b0;
			op_q         <= '0;
			key_q        <= '0;
			val_q        <= '0;
			idx_s1       <= '0;
			slot_q       <= '0;
			mcnt_q       <= '0;
			res_status_q <= ktable_pkg::ST_OK;
			res_found_q  <= 1'b0;
			res_value_q  <= '0;
			m_tdata_q    <= '0;
		end else begin
			// The output register is loaded when free, otherwise emptied on a handshake.
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q         <= req_op;
						key_q        <= req_key64[KEY_BITS-1:0];
						val_q        <= req_val64[VALUE_BITS-1:0];
						rd_idx_q     <= '0;
						v_s1         <= 1'b0;
						mcnt_q       <= '0;
						res_status_q <= ktable_pkg::ST_OK;
						res_found_q  <= 1'b0;
						res_value_q  <= '0;
						priority case (req_op)
							ktable_pkg::OP_INSERT: begin
								// Fullness is decided before any duplicate search.
								if (count_q >= CW'(TABLE_DEPTH)) begin
									res_status_q <= ktable_pkg::ST_FULL;
									state_q      <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ktable_pkg::OP_ERASE, ktable_pkg::OP_LOOKUP,
							ktable_pkg::OP_COUNT: begin
								state_q <= ST_SCAN;
							end
							ktable_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					v_s1   <= issue;
					idx_s1 <= rd_idx_q[AW-1:0];
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (op_q == ktable_pkg::OP_COUNT) begin
						if (val_hit) begin
							mcnt_q <= mcnt_q + 1'b1;
						end
						if (scan_end) begin
							state_q <= ST_DONE;
						end
					end else if (key_hit) begin
						priority case (op_q)
							ktable_pkg::OP_INSERT: begin
								res_status_q <= ktable_pkg::ST_DUPLICATE;
								state_q      <= ST_DONE;
							end
							ktable_pkg::OP_ERASE: begin
								res_found_q <= 1'b1;
								slot_q      <= idx_s1;
								state_q     <= ST_LAST;
							end
							default: begin
								res_found_q <= 1'b1;
								res_value_q <= rd_val;
								state_q     <= ST_DONE;
							end
						endcase
					end else if (scan_end) begin
						if (op_q == ktable_pkg::OP_INSERT) begin
							count_q <= count_q + 1'b1;
						end else begin
							res_status_q <= ktable_pkg::ST_NOT_FOUND;
						end
						state_q <= ST_DONE;
					end
				end
				ST_LAST: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					count_q <= last_idx;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata_q  <= {1'b0, occ16[5:0], mcnt16[5:0], res_val64[31:0],
							res_found_q, res_status_q};
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// The occupancy never exceeds the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("occupancy beyond table depth");

	// The occupancy moves by one entry at a time, or drops to zero on clear.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
		(count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1
		|| count_q == '0))
		else $error("occupancy changed by more than one entry");

	// Reads only touch valid entries.
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> CW'(ram_raddr) < count_q)
		else $error("read of an entry beyond the occupancy");

	// An erase move always follows the fetch of the last entry.
	a_move_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |=> state_q == ST_MOVE && ram_we)
		else $error("erase move not issued after fetching the last entry");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready && state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("pending response overwritten");

endmodule
